// ===== rtl/core/mett_pkg.sv =====
// shared types and constants for the mac endpoint traffic table
// no dependencies; used by the interfaces, the cell chain, the top level and the checker
package mett_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

   // field widths
   localparam int MAC_W      = 48;
   localparam int LEN_W      = 16;
   localparam int SLOT_W     = 6;
   localparam int CNT_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int ENTRIES_W  = 7;
   localparam int SLOT_CMP_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

   // function codes
   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // status bit positions
   localparam int STATUS_SRC_BIT = 0;
   localparam int STATUS_DST_BIT = 1;

   typedef logic [MAC_W-1:0]      mac_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [FILL_W-1:0]     fill_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [ENTRIES_W-1:0]  entries_type;
   typedef logic [SLOT_CMP_W-1:0] slot_cmp_type;

   // request token walking the cell chain
   typedef struct packed {
      logic    valid;
      logic    is_read;
      logic    is_rx;
      logic    hit;
      logic    inserted;
      mac_type key;
      len_type len;
      slot_type slot;
      cnt_type tx_packets;
      cnt_type tx_bytes;
      cnt_type rx_packets;
      cnt_type rx_bytes;
   } token_type;

endpackage

// ===== rtl/core/mett_if.sv =====
// request and response channel interfaces for the traffic table
// depends on mett_pkg
interface mett_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   mett_pkg::mac_type  src_mac;
   mett_pkg::mac_type  dst_mac;
   mett_pkg::len_type  frame_len;
   mett_pkg::slot_type read_slot;

   modport source(output valid, func, src_mac, dst_mac, frame_len, read_slot, input ready);
   modport sink(input valid, func, src_mac, dst_mac, frame_len, read_slot, output ready);
endinterface

interface mett_rsp_if;
   logic                  valid;
   logic                  ready;
   mett_pkg::status_type  status;
   logic                  slot_valid;
   mett_pkg::mac_type     slot_mac;
   mett_pkg::cnt_type     tx_packets;
   mett_pkg::cnt_type     tx_bytes;
   mett_pkg::cnt_type     rx_packets;
   mett_pkg::cnt_type     rx_bytes;
   mett_pkg::entries_type entries_used;

   modport source(output valid, status, slot_valid, slot_mac, tx_packets, tx_bytes,
                  rx_packets, rx_bytes, entries_used, input ready);
   modport sink(input valid, status, slot_valid, slot_mac, tx_packets, tx_bytes,
                rx_packets, rx_bytes, entries_used, output ready);
endinterface

// ===== rtl/core/mett_cell.sv =====
// one table entry: address, used flag and four saturating counters
// compares, updates or claims itself as a token passes; depends on mett_pkg
module mett_cell (
   input  logic                clock,
   input  logic                reset,
   input  mett_pkg::idx_type   cell_idx,
   input  mett_pkg::token_type up_tok,
   output mett_pkg::token_type dn_tok
);

   logic                used_ff, used_in;
   mett_pkg::mac_type   mac_ff, mac_in;
   mett_pkg::cnt_type   txp_ff, txp_in;
   mett_pkg::cnt_type   txb_ff, txb_in;
   mett_pkg::cnt_type   rxp_ff, rxp_in;
   mett_pkg::cnt_type   rxb_ff, rxb_in;
   mett_pkg::token_type dn_tok_ff, dn_tok_in;

   logic lookup;
   logic match;
   logic claim;
   logic pick;

   // add that sticks at all ones
   function automatic mett_pkg::cnt_type sat_add(input mett_pkg::cnt_type a,
                                                 input mett_pkg::cnt_type b);
      logic [mett_pkg::CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[mett_pkg::CNT_W] ? '1 : s[mett_pkg::CNT_W-1:0];
   endfunction

   // entry update and token hand-on
   always_comb begin
      lookup = up_tok.valid & ~up_tok.is_read & ~up_tok.hit;
      match  = lookup & used_ff & (mac_ff == up_tok.key);
      claim  = lookup & ~used_ff;
      pick   = up_tok.valid & up_tok.is_read & used_ff &
               (mett_pkg::slot_cmp_type'(up_tok.slot) == mett_pkg::slot_cmp_type'(cell_idx));

      used_in   = used_ff;
      mac_in    = mac_ff;
      txp_in    = txp_ff;
      txb_in    = txb_ff;
      rxp_in    = rxp_ff;
      rxb_in    = rxb_ff;
      dn_tok_in = up_tok;

      // known address: bump one side
      if (match) begin
         dn_tok_in.hit = 1'b1;
         if (up_tok.is_rx) begin
            rxp_in = sat_add(rxp_ff, mett_pkg::cnt_type'(1));
            rxb_in = sat_add(rxb_ff, mett_pkg::cnt_type'(up_tok.len));
         end else begin
            txp_in = sat_add(txp_ff, mett_pkg::cnt_type'(1));
            txb_in = sat_add(txb_ff, mett_pkg::cnt_type'(up_tok.len));
         end
      end

      // first free entry takes a new address, counters start from zero
      if (claim) begin
         used_in            = 1'b1;
         mac_in             = up_tok.key;
         dn_tok_in.hit      = 1'b1;
         dn_tok_in.inserted = 1'b1;
         if (up_tok.is_rx) begin
            txp_in = '0;
            txb_in = '0;
            rxp_in = mett_pkg::cnt_type'(1);
            rxb_in = mett_pkg::cnt_type'(up_tok.len);
         end else begin
            txp_in = mett_pkg::cnt_type'(1);
            txb_in = mett_pkg::cnt_type'(up_tok.len);
            rxp_in = '0;
            rxb_in = '0;
         end
      end

      // read of this slot picks up its contents
      if (pick) begin
         dn_tok_in.hit        = 1'b1;
         dn_tok_in.key        = mac_ff;
         dn_tok_in.tx_packets = txp_ff;
         dn_tok_in.tx_bytes   = txb_ff;
         dn_tok_in.rx_packets = rxp_ff;
         dn_tok_in.rx_bytes   = rxb_ff;
      end
   end

   // entry and token registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff         <= 1'b0;
         dn_tok_ff.valid <= 1'b0;
      end else begin
         used_ff   <= used_in;
         dn_tok_ff <= dn_tok_in;
      end
      mac_ff <= mac_in;
      txp_ff <= txp_in;
      txb_ff <= txb_in;
      rxp_ff <= rxp_in;
      rxb_ff <= rxb_in;
   end

   assign dn_tok = dn_tok_ff;

endmodule

// ===== rtl/core/mett_chain.sv =====
// row of table cells, a token moves one cell per clock
// depends on mett_pkg and mett_cell
module mett_chain (
   input  logic                clock,
   input  logic                reset,
   input  mett_pkg::token_type head_tok,
   output mett_pkg::token_type tail_tok
);

   mett_pkg::token_type link [0:mett_pkg::TABLE_ENTRIES];

   assign link[0] = head_tok;

   // one cell per table slot
   for (genvar i = 0; i < mett_pkg::TABLE_ENTRIES; i++) begin : g_cell
      mett_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (mett_pkg::idx_type'(i)),
         .up_tok   (link[i]),
         .dn_tok   (link[i+1])
      );
   end

   assign tail_tok = link[mett_pkg::TABLE_ENTRIES];

endmodule

// ===== rtl/core/mac_endpoint_traffic_table.sv =====
// top level of the mac endpoint traffic table: request sequencing and response register
// depends on mett_pkg, mett_req_if, mett_rsp_if and mett_chain
//
//   channel | dir | handshake          | carries
//   --------+-----+--------------------+-------------------------------------------
//   req_ch  | in  | valid/ready        | func, src_mac, dst_mac, frame_len, read_slot
//   rsp_ch  | out | valid/ready        | status, slot fields, counters, entries_used
//
// a request walks the row of TABLE_ENTRIES cells one cell per cycle; a record sends the
// source token and then the destination token in the next cycle
// response is offered once the read token or the destination token has left the chain and
// the response register is free; the sequencer then returns to idle for the next request
// one request at a time; a new request is taken while the last response still waits
// synchronous reset empties the table at once
module mac_endpoint_traffic_table (
   input  logic       clock,
   input  logic       reset,
   mett_req_if.sink   req_ch,
   mett_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {S_IDLE, S_DST, S_WAIT, S_DONE} state_type;

   state_type             state_ff;
   mett_pkg::token_type   inj_ff;
   mett_pkg::mac_type     dst_ff;
   mett_pkg::status_type  status_ff;
   mett_pkg::fill_type    fill_ff;
   mett_pkg::token_type   res_ff;
   mett_pkg::token_type   tail_tok;

   logic                  rsp_valid_ff;
   mett_pkg::status_type  rsp_status_ff;
   logic                  rsp_slot_valid_ff;
   mett_pkg::mac_type     rsp_mac_ff;
   mett_pkg::cnt_type     rsp_txp_ff;
   mett_pkg::cnt_type     rsp_txb_ff;
   mett_pkg::cnt_type     rsp_rxp_ff;
   mett_pkg::cnt_type     rsp_rxb_ff;
   mett_pkg::entries_type rsp_used_ff;

   logic req_fire;
   logic rsp_free;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign rsp_free     = ~rsp_valid_ff | rsp_ch.ready;

   // cell chain
   mett_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .head_tok (inj_ff),
      .tail_tok (tail_tok)
   );

   // sequencer, token injection and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inj_ff.valid <= 1'b0;
         fill_ff      <= '0;
         status_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response taken with nothing new behind it
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         // tokens leaving the chain
         if (tail_tok.valid) begin
            if (tail_tok.inserted) begin
               fill_ff <= fill_ff + mett_pkg::fill_type'(1);
            end
            if (!tail_tok.is_read && !tail_tok.hit) begin
               if (tail_tok.is_rx) begin
                  status_ff[mett_pkg::STATUS_DST_BIT] <= 1'b1;
               end else begin
                  status_ff[mett_pkg::STATUS_SRC_BIT] <= 1'b1;
               end
            end
         end

         case (state_ff)
            S_IDLE: begin
               inj_ff.valid <= req_fire;
               if (req_fire) begin
                  inj_ff.is_read    <= (req_ch.func == mett_pkg::FUNC_READ);
                  inj_ff.is_rx      <= 1'b0;
                  inj_ff.hit        <= 1'b0;
                  inj_ff.inserted   <= 1'b0;
                  inj_ff.key        <= (req_ch.func == mett_pkg::FUNC_READ) ? '0
                                                                           : req_ch.src_mac;
                  inj_ff.len        <= req_ch.frame_len;
                  inj_ff.slot       <= req_ch.read_slot;
                  inj_ff.tx_packets <= '0;
                  inj_ff.tx_bytes   <= '0;
                  inj_ff.rx_packets <= '0;
                  inj_ff.rx_bytes   <= '0;
                  dst_ff            <= req_ch.dst_mac;
                  status_ff         <= '0;
                  state_ff <= (req_ch.func == mett_pkg::FUNC_READ) ? S_WAIT : S_DST;
               end
            end
            S_DST: begin
               // destination token follows in the next cycle
               inj_ff.is_rx <= 1'b1;
               inj_ff.key   <= dst_ff;
               state_ff     <= S_WAIT;
            end
            S_WAIT: begin
               inj_ff.valid <= 1'b0;
               if (tail_tok.valid && (tail_tok.is_read || tail_tok.is_rx)) begin
                  res_ff   <= tail_tok;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_status_ff     <= status_ff;
                  rsp_slot_valid_ff <= res_ff.is_read & res_ff.hit;
                  rsp_mac_ff        <= res_ff.is_read ? res_ff.key : '0;
                  rsp_txp_ff        <= res_ff.tx_packets;
                  rsp_txb_ff        <= res_ff.tx_bytes;
                  rsp_rxp_ff        <= res_ff.rx_packets;
                  rsp_rxb_ff        <= res_ff.rx_bytes;
                  rsp_used_ff       <= mett_pkg::entries_type'(fill_ff);
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.slot_valid   = rsp_slot_valid_ff;
   assign rsp_ch.slot_mac     = rsp_mac_ff;
   assign rsp_ch.tx_packets   = rsp_txp_ff;
   assign rsp_ch.tx_bytes     = rsp_txb_ff;
   assign rsp_ch.rx_packets   = rsp_rxp_ff;
   assign rsp_ch.rx_bytes     = rsp_rxb_ff;
   assign rsp_ch.entries_used = rsp_used_ff;

endmodule

// ===== rtl/core/mett_checker.sv =====
// port-level checks for the mac endpoint traffic table, bound to the top level
// depends on mett_pkg and mac_endpoint_traffic_table
module mett_assertions (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mett_pkg::status_type  rsp_status,
   input logic                  rsp_slot_valid,
   input mett_pkg::mac_type     rsp_slot_mac,
   input mett_pkg::cnt_type     rsp_tx_packets,
   input mett_pkg::cnt_type     rsp_tx_bytes,
   input mett_pkg::cnt_type     rsp_rx_packets,
   input mett_pkg::cnt_type     rsp_rx_bytes,
   input mett_pkg::entries_type rsp_entries_used
);

   // busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in the chain");

   // a response is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

   // a miss status only comes from a record, which reports no slot
   a_status_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != '0)) |-> !rsp_slot_valid)
      else $error("slot reported alongside a record status");

   // an empty slot reports all zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_slot_valid) |->
         (rsp_slot_mac == '0) && (rsp_tx_packets == '0) && (rsp_tx_bytes == '0) &&
         (rsp_rx_packets == '0) && (rsp_rx_bytes == '0))
      else $error("empty slot with non-zero contents");

   // fill count never goes past the table size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mett_pkg::TABLE_ENTRIES > 127) ||
         (rsp_entries_used <= mett_pkg::entries_type'(mett_pkg::TABLE_ENTRIES)))
      else $error("entries used beyond table size");

endmodule

bind mac_endpoint_traffic_table mett_assertions u_mett_assertions (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_slot_valid   (rsp_ch.slot_valid),
   .rsp_slot_mac     (rsp_ch.slot_mac),
   .rsp_tx_packets   (rsp_ch.tx_packets),
   .rsp_tx_bytes     (rsp_ch.tx_bytes),
   .rsp_rx_packets   (rsp_ch.rx_packets),
   .rsp_rx_bytes     (rsp_ch.rx_bytes),
   .rsp_entries_used (rsp_ch.entries_used)
);
